[rtl/irpd_pkg.sv]
package irpd_pkg;

	localparam int DUR_W = 15;
	localparam int PAIR_W = 2 * DUR_W;
	localparam int FIELD_W = 15;
	localparam int LEN_W = 4;
	localparam int OPT_W = 3;
	localparam int CNT_W = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = PAIR_W;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEADER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ADDR_LEN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CMD_LEN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OPTIONS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED = 3'd7;

	// frame option bits
	localparam int OPT_ADDR_INV = 0;
	localparam int OPT_CMD_INV = 1;
	localparam int OPT_STOP = 2;

	localparam logic [PAIR_W-1:0] RST_HEADER = 30'd147465000;
	localparam logic [PAIR_W-1:0] RST_ONE = 30'd55378480;
	localparam logic [PAIR_W-1:0] RST_ZERO = 30'd18350640;
	localparam logic [PAIR_W-1:0] RST_STOP = 30'd560;
	localparam logic [LEN_W-1:0] RST_ADDR_LEN = 4'd8;
	localparam logic [LEN_W-1:0] RST_CMD_LEN = 4'd8;
	localparam logic [OPT_W-1:0] RST_OPTIONS = 3'd7;
	localparam logic [CNT_W-1:0] RST_EXPECTED = 6'd34;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_ADDR,
		PH_ADDR_INV,
		PH_CMD,
		PH_CMD_INV,
		PH_STOP
	} phase_t;

	typedef struct packed {
		logic [PAIR_W-1:0] header_durations;
		logic [PAIR_W-1:0] one_durations;
		logic [PAIR_W-1:0] zero_durations;
		logic [PAIR_W-1:0] stop_durations;
		logic [LEN_W-1:0] address_length;
		logic [LEN_W-1:0] command_length;
		logic [OPT_W-1:0] frame_options;
		logic [CNT_W-1:0] expected_item_count;
	} cfg_t;

	typedef struct packed {
		logic [FIELD_W-1:0] address;
		logic [FIELD_W-1:0] command;
	} in_item_t;

	typedef struct packed {
		logic [DUR_W-1:0] mark_ticks;
		logic [DUR_W-1:0] space_ticks;
		logic last_item;
		logic frame_ok;
	} out_item_t;

	// one queued frame request
	typedef struct packed {
		logic [FIELD_W-1:0] address;
		logic [FIELD_W-1:0] command;
		logic frame_ok;
	} frame_t;

	function automatic logic section_enabled(phase_t ph, cfg_t c);
		logic en;
		case (ph)
			PH_ADDR: en = (c.address_length != '0);
			PH_ADDR_INV: en = (c.address_length != '0) && c.frame_options[OPT_ADDR_INV];
			PH_CMD: en = (c.command_length != '0);
			PH_CMD_INV: en = (c.command_length != '0) && c.frame_options[OPT_CMD_INV];
			PH_STOP: en = c.frame_options[OPT_STOP];
			default: en = 1'b0;
		endcase
		return en;
	endfunction

	// first enabled section after cur, idle when none remains
	function automatic phase_t next_section(phase_t cur, cfg_t c);
		phase_t res;
		logic found;
		res = PH_IDLE;
		found = 1'b0;
		for (int i = int'(PH_ADDR); i <= int'(PH_STOP); i++) begin
			if (!found && (i > int'(cur)) && section_enabled(phase_t'(i[2:0]), c)) begin
				res = phase_t'(i[2:0]);
				found = 1'b1;
			end
		end
		return res;
	endfunction

endpackage

[rtl/ir_pulse_distance_frame_encoder_top.sv]
// Pulse-distance infrared frame encoder. Each accepted request (address, command) becomes
// one frame of mark/space items: a header, the low address_length address bits LSB first,
// optionally their inverse, the low command_length command bits, optionally their inverse,
// and optionally a stop item; the last item is flagged and reports whether the item count
// matched expected_item_count. The output sequencer emits one item per cycle while the output
// is not stalled, and a frame has N items (N = 1 + a*(1+inv_a) + c*(1+inv_c) + stop, at most 62);
// between frames the sequencer passes through its idle state to fetch the next request from
// a two-entry queue; the queue lets up to two requests be taken while a frame is still
// being sent. Registers reset to the usual NEC timing (9000/4500 header,
// 560/1690 one, 560/560 zero, 560/0 stop, 8-bit fields, all options on, 34 items) and are
// to be written only while the block is idle.
module ir_pulse_distance_frame_encoder_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  irpd_pkg::in_item_t                    in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output irpd_pkg::out_item_t                   out_data,
	input  logic                                  cfg_we,
	input  logic [irpd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [irpd_pkg::CFG_DATA_W-1:0]       cfg_data
);

	irpd_pkg::cfg_t cfg_q;
	irpd_pkg::frame_t push_entry;
	irpd_pkg::frame_t q_entry;
	logic push;
	logic pop;
	logic q_full;
	logic q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_durations <= irpd_pkg::RST_HEADER;
			cfg_q.one_durations <= irpd_pkg::RST_ONE;
			cfg_q.zero_durations <= irpd_pkg::RST_ZERO;
			cfg_q.stop_durations <= irpd_pkg::RST_STOP;
			cfg_q.address_length <= irpd_pkg::RST_ADDR_LEN;
			cfg_q.command_length <= irpd_pkg::RST_CMD_LEN;
			cfg_q.frame_options <= irpd_pkg::RST_OPTIONS;
			cfg_q.expected_item_count <= irpd_pkg::RST_EXPECTED;
		end else if (cfg_we) begin
			case (cfg_index)
				irpd_pkg::REG_HEADER: cfg_q.header_durations <= cfg_data;
				irpd_pkg::REG_ONE: cfg_q.one_durations <= cfg_data;
				irpd_pkg::REG_ZERO: cfg_q.zero_durations <= cfg_data;
				irpd_pkg::REG_STOP: cfg_q.stop_durations <= cfg_data;
				irpd_pkg::REG_ADDR_LEN:
					cfg_q.address_length <= cfg_data[irpd_pkg::LEN_W-1:0];
				irpd_pkg::REG_CMD_LEN:
					cfg_q.command_length <= cfg_data[irpd_pkg::LEN_W-1:0];
				irpd_pkg::REG_OPTIONS:
					cfg_q.frame_options <= cfg_data[irpd_pkg::OPT_W-1:0];
				irpd_pkg::REG_EXPECTED:
					cfg_q.expected_item_count <= cfg_data[irpd_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	irpd_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.cfg        (cfg_q),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	irpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (push_entry),
		.full      (q_full),
		.pop       (pop),
		.rdata     (q_entry),
		.not_empty (q_not_empty)
	);

	irpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_entry     (q_entry),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

[rtl/irpd_front.sv]
module irpd_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  irpd_pkg::in_item_t in_data,
	input  irpd_pkg::cfg_t     cfg,
	input  logic               q_full,
	output logic               push,
	output irpd_pkg::frame_t   push_entry
);

	logic [irpd_pkg::CNT_W-1:0] addr_len;
	logic [irpd_pkg::CNT_W-1:0] cmd_len;
	logic [irpd_pkg::CNT_W-1:0] item_count;

	// item count of the frame: header, fields, inverted copies, stop
	always_comb begin
		addr_len = {2'b00, cfg.address_length};
		cmd_len = {2'b00, cfg.command_length};
		item_count = irpd_pkg::CNT_W'(1) + addr_len
			+ (cfg.frame_options[irpd_pkg::OPT_ADDR_INV] ? addr_len : '0)
			+ cmd_len
			+ (cfg.frame_options[irpd_pkg::OPT_CMD_INV] ? cmd_len : '0)
			+ {{(irpd_pkg::CNT_W-1){1'b0}}, cfg.frame_options[irpd_pkg::OPT_STOP]};
	end

	assign in_ready = !q_full;
	assign push = in_valid && !q_full;

	always_comb begin
		push_entry.address = in_data.address;
		push_entry.command = in_data.command;
		push_entry.frame_ok = (item_count == cfg.expected_item_count);
	end

endmodule

[rtl/irpd_queue.sv]
module irpd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  irpd_pkg::frame_t wdata,
	output logic             full,
	input  logic             pop,
	output irpd_pkg::frame_t rdata,
	output logic             not_empty
);

	irpd_pkg::frame_t mem_q [irpd_pkg::QDEPTH];
	logic [irpd_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [irpd_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [irpd_pkg::QCNT_W-1:0] count_q;

	assign full = (count_q == irpd_pkg::QCNT_W'(irpd_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == irpd_pkg::QPTR_W'(irpd_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == irpd_pkg::QPTR_W'(irpd_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= irpd_pkg::QCNT_W'(irpd_pkg::QDEPTH))
		else $error("queue holds more requests than it has entries");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("request popped from an empty queue");

endmodule

[rtl/irpd_back.sv]
module irpd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  irpd_pkg::cfg_t      cfg,
	input  logic                q_not_empty,
	input  irpd_pkg::frame_t    q_entry,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output irpd_pkg::out_item_t out_data
);

	irpd_pkg::phase_t phase_q, phase_d;
	logic [irpd_pkg::LEN_W-1:0] bit_q, bit_d;
	logic [irpd_pkg::FIELD_W-1:0] address_q;
	logic [irpd_pkg::FIELD_W-1:0] command_q;
	logic frame_ok_q;
	logic out_valid_q;
	irpd_pkg::out_item_t out_q;

	logic load;
	logic emit;
	logic last;
	logic [irpd_pkg::PAIR_W-1:0] pair;
	logic [irpd_pkg::FIELD_W-1:0] data;
	logic [irpd_pkg::LEN_W-1:0] len;
	logic bit_val;
	irpd_pkg::phase_t nxt;
	irpd_pkg::out_item_t item;

	// the output register can take a new item when empty or being drained
	assign load = !out_valid_q || out_ready;

	always_comb begin
		phase_d = phase_q;
		bit_d = bit_q;
		pop = 1'b0;
		emit = 1'b0;
		last = 1'b0;
		pair = cfg.header_durations;
		nxt = irpd_pkg::next_section(phase_q, cfg);
		if ((phase_q == irpd_pkg::PH_ADDR) || (phase_q == irpd_pkg::PH_ADDR_INV)) begin
			data = address_q;
			len = cfg.address_length;
		end else begin
			data = command_q;
			len = cfg.command_length;
		end
		bit_val = data[bit_q] ^
			((phase_q == irpd_pkg::PH_ADDR_INV) || (phase_q == irpd_pkg::PH_CMD_INV));
		case (phase_q)
			irpd_pkg::PH_IDLE: begin
				if (q_not_empty) begin
					pop = 1'b1;
					phase_d = irpd_pkg::PH_HEADER;
				end
			end
			irpd_pkg::PH_HEADER: begin
				if (load) begin
					emit = 1'b1;
					pair = cfg.header_durations;
					last = (nxt == irpd_pkg::PH_IDLE);
					phase_d = nxt;
					bit_d = '0;
				end
			end
			irpd_pkg::PH_ADDR, irpd_pkg::PH_ADDR_INV,
			irpd_pkg::PH_CMD, irpd_pkg::PH_CMD_INV: begin
				if (load) begin
					emit = 1'b1;
					pair = bit_val ? cfg.one_durations : cfg.zero_durations;
					if (bit_q == len - 1'b1) begin
						last = (nxt == irpd_pkg::PH_IDLE);
						phase_d = nxt;
						bit_d = '0;
					end else begin
						bit_d = bit_q + 1'b1;
					end
				end
			end
			irpd_pkg::PH_STOP: begin
				if (load) begin
					emit = 1'b1;
					pair = cfg.stop_durations;
					last = 1'b1;
					phase_d = irpd_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = irpd_pkg::PH_IDLE;
			end
		endcase
		item.mark_ticks = pair[irpd_pkg::DUR_W-1:0];
		item.space_ticks = pair[irpd_pkg::PAIR_W-1:irpd_pkg::DUR_W];
		item.last_item = last;
		item.frame_ok = last && frame_ok_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= irpd_pkg::PH_IDLE;
			bit_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			bit_q <= bit_d;
			if (load) begin
				out_valid_q <= emit;
			end
		end
	end

	// hold the request and the item payload
	always_ff @(posedge clk) begin
		if (pop) begin
			address_q <= q_entry.address;
			command_q <= q_entry.command;
			frame_ok_q <= q_entry.frame_ok;
		end
		if (load && emit) begin
			out_q <= item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (phase_q == irpd_pkg::PH_IDLE))
		else $error("request taken while a frame is in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.frame_ok) |-> out_q.last_item)
		else $error("frame check flag on an item that does not close the frame");

	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last) |=> (phase_q == irpd_pkg::PH_IDLE))
		else $error("sequencer kept running after the last item");

	assert property (@(posedge clk) disable iff (!arst_n)
		((phase_q == irpd_pkg::PH_ADDR) || (phase_q == irpd_pkg::PH_ADDR_INV)) |->
		(bit_q < cfg.address_length))
		else $error("address bit index past the field length");

endmodule
